@@ design/lzpf_pkg.sv @@
// Shared constants, types and command/status bundles for the LZ77 factor decoder.
package lzpf_pkg;

   localparam int HISTORY_DEPTH  = 65536;
   localparam int HIST_AW        = $clog2(HISTORY_DEPTH);
   localparam int MAX_LOG_LENGTH = 7;
   localparam int COUNT_W        = MAX_LOG_LENGTH;
   localparam int LOG_W          = 3;
   localparam int POS_W          = 32;
   localparam int BYTE_W         = 8;

   localparam logic [POS_W-1:0] HIST_DEPTH_W = POS_W'(HISTORY_DEPTH);
   localparam logic [LOG_W-1:0] MAX_LOG_W    = LOG_W'(MAX_LOG_LENGTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_COPY
   } state_type;

   typedef enum logic [1:0] {
      KIND_COPY,
      KIND_LIT,
      KIND_ERR
   } kind_type;

   typedef struct packed {
      logic load_req;
      logic start_copy;
      logic issue_copy;
      logic issue_lit;
      logic issue_err;
   } cmd_type;

   typedef struct packed {
      logic pend;
      logic can_issue;
      logic zero_lit;
      logic literal;
      logic bad_ref;
      logic last_copy;
      logic fifo_full;
      logic landing;
   } sts_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last_of_run;
      logic              bad_reference;
   } rsp_type;

endpackage

@@ design/lzpf_datapath.sv @@
// Datapath: request latch, position counters, history RAM, read pipeline and response queue.
module lzpf_datapath
   import lzpf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [LOG_W-1:0]  req_log_length,
   input  logic [BYTE_W-1:0] req_literal_byte,
   input  logic [POS_W-1:0]  req_ref_position,
   input  cmd_type           cmd,
   output sts_type           sts,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_last_of_run,
   output logic              rsp_bad_reference
);

   logic [LOG_W-1:0]   lg_ff;
   logic [BYTE_W-1:0]  lit_ff;
   logic [POS_W-1:0]   ref_ff;
   logic [POS_W-1:0]   bw_ff, bw_in;
   logic [POS_W-1:0]   src_ff, src_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;

   logic               pend_ff;
   kind_type           kind_ff, kind_in;
   logic               last_ff, last_in;
   logic [BYTE_W-1:0]  pdata_ff;
   logic               fwd_ff, fwd_in;
   logic [BYTE_W-1:0]  fwd_data_ff;
   logic [BYTE_W-1:0]  mem_rd_ff;

   logic [BYTE_W-1:0]  hist_mem [HISTORY_DEPTH];

   rsp_type            fifo_ff [2];
   logic               wr_ptr_ff, rd_ptr_ff;
   logic [1:0]         cnt_ff, cnt_in;

   logic [POS_W-1:0]   ref_dist;
   logic [LOG_W-1:0]   lg_sat;
   logic [COUNT_W-1:0] copy_len;
   logic [HIST_AW-1:0] rd_addr;
   logic [HIST_AW-1:0] wr_addr;
   logic [BYTE_W-1:0]  land_data;
   logic               land_write;
   logic               issue;
   logic               push;
   logic               pop;
   logic [2:0]         occ_next;
   rsp_type            push_item;

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         lg_ff  <= req_log_length;
         lit_ff <= req_literal_byte;
         ref_ff <= req_ref_position;
      end
   end

   assign ref_dist = bw_ff - ref_ff;
   assign lg_sat   = (lg_ff > MAX_LOG_W) ? MAX_LOG_W : lg_ff;
   assign copy_len = COUNT_W'(1) << (lg_sat - LOG_W'(1));
   assign rd_addr  = src_ff[HIST_AW-1:0];
   assign wr_addr  = bw_ff[HIST_AW-1:0];
   assign issue    = cmd.issue_copy | cmd.issue_lit | cmd.issue_err;

   assign land_write = pend_ff && (kind_ff != KIND_ERR);

   always_comb begin
      case (kind_ff)
         KIND_LIT:  land_data = pdata_ff;
         KIND_COPY: land_data = fwd_ff ? fwd_data_ff : mem_rd_ff;
         default:   land_data = '0;
      endcase
   end

   always_comb begin
      bw_in  = land_write ? bw_ff + POS_W'(1) : bw_ff;
      src_in = src_ff;
      rem_in = rem_ff;
      if (cmd.start_copy) begin
         src_in = ref_ff;
         rem_in = copy_len;
      end else if (cmd.issue_copy) begin
         src_in = src_ff + POS_W'(1);
         rem_in = rem_ff - COUNT_W'(1);
      end
   end

   always_comb begin
      kind_in = KIND_COPY;
      last_in = 1'b1;
      if (cmd.issue_lit) begin
         kind_in = KIND_LIT;
      end else if (cmd.issue_err) begin
         kind_in = KIND_ERR;
      end else begin
         last_in = (rem_ff == COUNT_W'(1));
      end
   end

   // same-cycle write/read of one entry: forward the written byte
   assign fwd_in = cmd.issue_copy && land_write && (rd_addr == wr_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         bw_ff   <= '0;
         src_ff  <= '0;
         rem_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         bw_ff   <= bw_in;
         src_ff  <= src_in;
         rem_ff  <= rem_in;
         pend_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         kind_ff     <= kind_in;
         last_ff     <= last_in;
         pdata_ff    <= lit_ff;
         fwd_ff      <= fwd_in;
         fwd_data_ff <= land_data;
      end
   end

   // history RAM
   always_ff @(posedge clock) begin
      if (land_write) begin
         hist_mem[wr_addr] <= land_data;
      end
      if (cmd.issue_copy) begin
         mem_rd_ff <= hist_mem[rd_addr];
      end
   end

   // two-entry response queue
   assign push = pend_ff;
   assign pop  = (cnt_ff != 2'd0) && rsp_ready;

   assign push_item.out_byte      = land_data;
   assign push_item.last_of_run   = last_ff;
   assign push_item.bad_reference = (kind_ff == KIND_ERR);

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign rsp_valid         = (cnt_ff != 2'd0);
   assign rsp_out_byte      = fifo_ff[rd_ptr_ff].out_byte;
   assign rsp_last_of_run   = fifo_ff[rd_ptr_ff].last_of_run;
   assign rsp_bad_reference = fifo_ff[rd_ptr_ff].bad_reference;

   // a new issue is pushed once it reaches pend_ff; the queue must have room for it by then
   assign occ_next = {1'b0, cnt_ff} - {2'b00, pop} + {2'b00, pend_ff};

   assign sts.pend      = pend_ff;
   assign sts.can_issue = (occ_next <= 3'd1);
   assign sts.zero_lit  = (lg_ff == '0) && (lit_ff == '0);
   assign sts.literal   = (lg_ff == '0);
   assign sts.bad_ref   = (ref_ff >= bw_ff) || (ref_dist > HIST_DEPTH_W);
   assign sts.last_copy = (rem_ff == COUNT_W'(1));
   assign sts.fifo_full = (cnt_ff == 2'd2);
   assign sts.landing   = push;

endmodule

@@ design/lzpf_ctrl.sv @@
// Controller: state machine that sequences decode, literal, error and copy requests.
module lzpf_ctrl
   import lzpf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (!sts.pend) begin
               if (sts.zero_lit) begin
                  state_in = ST_IDLE;
               end else if (sts.can_issue) begin
                  if (sts.literal || sts.bad_ref) begin
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_COPY;
                  end
               end
            end
         end
         ST_COPY: begin
            if (sts.can_issue && sts.last_copy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         ST_DECODE: begin
            if (!sts.pend && !sts.zero_lit && sts.can_issue) begin
               if (sts.literal) begin
                  cmd.issue_lit = 1'b1;
               end else if (sts.bad_ref) begin
                  cmd.issue_err = 1'b1;
               end else begin
                  cmd.start_copy = 1'b1;
               end
            end
         end
         ST_COPY: begin
            cmd.issue_copy = sts.can_issue;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

@@ design/lz77_pow2_factor_decoder.sv @@
// Top level of the LZ77 power-of-two factor decoder.
//
// Usage: one factor per request on req_* (valid/ready); decoded bytes leave
// one per response on rsp_* (valid/ready), rsp_last_of_run marking the final
// response of a factor. A literal (log length 0) gives its byte; a zero
// literal gives nothing. A copy of N = 2^(log_length-1) bytes (N <= 64) reads
// the 64 KiB history RAM at its absolute source position; overlapping copies
// repeat with the distance as period. A source in the future or beyond the
// window gives one response with rsp_bad_reference set.
// Timing: req_ready is high only between requests. A literal or error is issued
// from the decode state; a copy is started there and issues one byte per cycle
// from the copy state while the queue has room, bounded by the single RAM read
// port. Each byte passes a landing register before it enters the response queue.
// Reset clears the byte count and all control state; history is not cleared.
// When the receiver stalls, a two-entry response queue fills and the copy
// sequencer pauses until there is room, losing no byte.
module lz77_pow2_factor_decoder
   import lzpf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [LOG_W-1:0]  req_log_length,
   input  logic [BYTE_W-1:0] req_literal_byte,
   input  logic [POS_W-1:0]  req_ref_position,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_last_of_run,
   output logic              rsp_bad_reference
);

   cmd_type cmd;
   sts_type sts;

   lzpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lzpf_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_log_length    (req_log_length),
      .req_literal_byte  (req_literal_byte),
      .req_ref_position  (req_ref_position),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_bad_reference (rsp_bad_reference)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(sts.landing && sts.fifo_full && !rsp_ready))
      else $error("response queue overflow");

   a_issue_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.issue_copy || cmd.issue_lit || cmd.issue_err) |-> sts.can_issue)
      else $error("issue without queue room");

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while busy");

   a_error_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_reference) |-> (rsp_last_of_run && rsp_out_byte == '0))
      else $error("malformed error response");

endmodule

@@ tb/sv/tb_lz77_pow2_factor_decoder.sv @@
// Self-checking testbench for the LZ77 power-of-two factor decoder.
module tb_lz77_pow2_factor_decoder;
   import lzpf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_DIRECTED      = 21;
   localparam int N_RANDOM_FIRST  = 130;
   localparam int N_RANDOM_SECOND = 200;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 20;

   localparam logic [LOG_W-1:0] LOG_LITERAL = '0;

   typedef enum logic [1:0] {
      CHK_MODEL,
      CHK_NONE,
      CHK_ONE
   } check_type;

   typedef struct packed {
      check_type         chk;
      logic [LOG_W-1:0]  lg_code;
      logic [BYTE_W-1:0] literal_byte;
      logic [POS_W-1:0]  src_pos;
      rsp_type           want;
   } factor_type;

   localparam rsp_type BAD_REF = '{out_byte: '0, last_of_run: 1'b1, bad_reference: 1'b1};
   localparam rsp_type NO_RSP  = '0;

   localparam factor_type DIRECTED_FACTORS [N_DIRECTED] = '{
      '{CHK_ONE,   3'd1, 8'h00, 32'd0,        BAD_REF},
      '{CHK_NONE,  3'd0, 8'h00, 32'hFFFF_FFFF, NO_RSP},
      '{CHK_ONE,   3'd0, 8'hFF, 32'd0,        '{8'hFF, 1'b1, 1'b0}},
      '{CHK_ONE,   3'd0, 8'h01, 32'd0,        '{8'h01, 1'b1, 1'b0}},
      '{CHK_ONE,   3'd0, 8'h80, 32'd0,        '{8'h80, 1'b1, 1'b0}},
      '{CHK_ONE,   3'd0, 8'h7F, 32'd0,        '{8'h7F, 1'b1, 1'b0}},
      '{CHK_MODEL, 3'd1, 8'hFF, 32'd3,        NO_RSP},
      '{CHK_MODEL, 3'd2, 8'h00, 32'd4,        NO_RSP},
      '{CHK_MODEL, 3'd3, 8'h5A, 32'd0,        NO_RSP},
      '{CHK_MODEL, 3'd4, 8'h00, 32'd10,       NO_RSP},
      '{CHK_MODEL, 3'd5, 8'h00, 32'd17,       NO_RSP},
      '{CHK_MODEL, 3'd6, 8'h00, 32'd0,        NO_RSP},
      '{CHK_MODEL, 3'd7, 8'h00, 32'd0,        NO_RSP},
      '{CHK_MODEL, 3'd7, 8'hFF, 32'd130,      NO_RSP},
      '{CHK_ONE,   3'd1, 8'h00, 32'd195,      BAD_REF},
      '{CHK_ONE,   3'd7, 8'h00, 32'hFFFF_FFFF, BAD_REF},
      '{CHK_MODEL, 3'd2, 8'h00, 32'd194,      NO_RSP},
      '{CHK_ONE,   3'd0, 8'h55, 32'h1234_5678, '{8'h55, 1'b1, 1'b0}},
      '{CHK_ONE,   3'd0, 8'hAA, 32'hEDCB_A987, '{8'hAA, 1'b1, 1'b0}},
      '{CHK_MODEL, 3'd3, 8'h00, 32'd196,      NO_RSP},
      '{CHK_MODEL, 3'd1, 8'h00, 32'd202,      NO_RSP}
   };

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [LOG_W-1:0]  req_log_length;
   logic [BYTE_W-1:0] req_literal_byte;
   logic [POS_W-1:0]  req_ref_position;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic              rsp_last_of_run;
   logic              rsp_bad_reference;

   logic [BYTE_W-1:0] history_ram [HISTORY_DEPTH];
   logic [POS_W-1:0]  out_count;
   rsp_type           decoded [64];
   rsp_type           expected_bytes [$];
   int                mismatch_count;

   lz77_pow2_factor_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_log_length    (req_log_length),
      .req_literal_byte  (req_literal_byte),
      .req_ref_position  (req_ref_position),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_bad_reference (rsp_bad_reference)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Bytes one factor produces; a literal or copy also updates history and byte count.
   function automatic int decode_factor(input logic [LOG_W-1:0]  lg,
                                        input logic [BYTE_W-1:0] lit,
                                        input logic [POS_W-1:0]  src);
      logic [LOG_W-1:0] eff_log;
      logic [POS_W-1:0] back_dist;
      logic [POS_W-1:0] rd_pos;
      int               len;
      int               i;
      if (lg == LOG_LITERAL) begin
         if (lit == '0)
            return 0;
         history_ram[out_count[HIST_AW-1:0]] = lit;
         out_count++;
         decoded[0] = '{out_byte: lit, last_of_run: 1'b1, bad_reference: 1'b0};
         return 1;
      end
      eff_log = (lg > MAX_LOG_W) ? MAX_LOG_W : lg;
      back_dist = out_count - src;
      if (src >= out_count || back_dist > HIST_DEPTH_W) begin
         decoded[0] = BAD_REF;
         return 1;
      end
      len = 1 << (eff_log - 1);
      rd_pos = src;
      for (i = 0; i < len; i++) begin
         decoded[i].out_byte      = history_ram[rd_pos[HIST_AW-1:0]];
         decoded[i].last_of_run   = (i == len - 1);
         decoded[i].bad_reference = 1'b0;
         history_ram[out_count[HIST_AW-1:0]] = decoded[i].out_byte;
         rd_pos++;
         out_count++;
      end
      return len;
   endfunction

   task automatic send_factor(input logic [LOG_W-1:0]  lg,
                              input logic [BYTE_W-1:0] lit,
                              input logic [POS_W-1:0]  src,
                              input check_type         chk,
                              input rsp_type           typed_rsp);
      int gap;
      int n;
      int i;
      gap = $urandom_range(0, 4);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_log_length   <= lg;
      req_literal_byte <= lit;
      req_ref_position <= src;
      do @(posedge clock); while (!req_ready);
      n = decode_factor(lg, lit, src);
      case (chk)
         CHK_MODEL: begin
            for (i = 0; i < n; i++)
               expected_bytes.insert(expected_bytes.size(), decoded[i]);
         end
         CHK_ONE:   expected_bytes.insert(expected_bytes.size(), typed_rsp);
         default:   ;
      endcase
   endtask

   task automatic hold_requests();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_bytes.size() != 0)
         @(posedge clock);
   endtask

   task automatic send_random_factor();
      logic [LOG_W-1:0]  lg;
      logic [BYTE_W-1:0] lit;
      logic [POS_W-1:0]  src;
      int                pick;
      int                span;
      lg   = LOG_W'($urandom_range(1, 7));
      lit  = BYTE_W'($urandom);
      src  = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 25 || out_count == 0) begin
         lg = LOG_LITERAL;
         if ($urandom_range(0, 7) == 0)
            lit = '0;
      end else if (pick < 35) begin
         src = $urandom_range(0, 1) ? out_count + $urandom_range(0, 255)
                                    : ($urandom | 32'h8000_0000);
      end else begin
         span = (out_count > HIST_DEPTH_W) ? HISTORY_DEPTH : int'(out_count);
         if ($urandom_range(0, 1) && span > 8)
            span = 8;
         src = out_count - $urandom_range(1, span);
      end
      send_factor(lg, lit, src, CHK_MODEL, NO_RSP);
   endtask

   // receiver: random stall before each response
   initial begin : receiver
      int stall;
      rsp_ready = 1'b0;
      forever begin
         stall = $urandom_range(0, 4);
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin : response_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            $error("unexpected response: out_byte %02h last_of_run %0b bad_reference %0b",
                   rsp_out_byte, rsp_last_of_run, rsp_bad_reference);
            mismatch_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_out_byte !== want.out_byte) begin
               $error("out_byte: expected %02h, got %02h", want.out_byte, rsp_out_byte);
               mismatch_count++;
            end
            if (rsp_last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %0b, got %0b",
                      want.last_of_run, rsp_last_of_run);
               mismatch_count++;
            end
            if (rsp_bad_reference !== want.bad_reference) begin
               $error("bad_reference: expected %0b, got %0b",
                      want.bad_reference, rsp_bad_reference);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      int i;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_log_length   = '0;
      req_literal_byte = '0;
      req_ref_position = '0;
      out_count        = '0;
      mismatch_count   = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < N_DIRECTED; i++)
         send_factor(DIRECTED_FACTORS[i].lg_code, DIRECTED_FACTORS[i].literal_byte,
                     DIRECTED_FACTORS[i].src_pos, DIRECTED_FACTORS[i].chk,
                     DIRECTED_FACTORS[i].want);

      for (i = 0; i < N_RANDOM_FIRST; i++)
         send_random_factor();

      // sender holds off until every response is back
      hold_requests();
      wait_drained();

      for (i = 0; i < N_RANDOM_SECOND; i++)
         send_random_factor();

      hold_requests();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ sim.f @@
design/lzpf_pkg.sv
design/lzpf_datapath.sv
design/lzpf_ctrl.sv
design/lz77_pow2_factor_decoder.sv
tb/sv/tb_lz77_pow2_factor_decoder.sv
